>>> hdl/ascm_pkg.sv
package ascm_pkg;

  localparam int MASK_WIDTH        = 8;
  localparam int ROW_WIDTH         = 3;
  localparam int IN_COST_WIDTH     = 16;
  localparam int OUT_COST_WIDTH    = 16;
  localparam int SYMS_WIDTH        = 4;
  localparam int DEF_ALPHABET      = 8;
  localparam int DEF_COST_BITS     = 16;

  localparam logic [OUT_COST_WIDTH-1:0] NO_PAIR_COST = 16'hFFFF;
  localparam logic [SYMS_WIDTH-1:0]     SYMS_RESET   = 4'd8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } ascm_state_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } ascm_acc_ctrl_t;

endpackage

>>> hdl/ascm_accum.sv
module ascm_accum
  import ascm_pkg::*;
#(
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ascm_acc_ctrl_t        ctrl,
  input  logic [COST_BITS-1:0]  cost,
  input  logic [MASK_WIDTH-1:0] pair_mask,
  output logic [COST_BITS-1:0]  best,
  output logic [MASK_WIDTH-1:0] median,
  output logic                  any
);

  always_ff @(posedge clk) begin
    if (rst) begin
      any    <= 1'b0;
      median <= '0;
    end else if (ctrl.clear) begin
      any    <= 1'b0;
      median <= '0;
    end else if (ctrl.sample) begin
      if (!any || cost < best) begin
        any    <= 1'b1;
        best   <= cost;
        median <= pair_mask;
      end else if (cost == best) begin
        median <= median | pair_mask;
      end
    end
  end

endmodule

>>> hdl/ambiguity_set_cost_median_top.sv
// Channel   Handshake            Payload
// config    cfg_write            cfg_data (symbols_in_use)
// input     start & !busy        operation, left_set, right_set, entry_row, entry_col, entry_cost
// result    result_valid         min_cost, median_set, no_pair
//
// A write leaves busy low; it produces no result.
// A query scans all NUSE*NUSE table entries (NUSE = min(ALPHABET, 8)), one
// cost memory read per cycle, then passes through ST_DRAIN and ST_REPORT;
// a query with an empty masked set goes straight to ST_REPORT. The single read port sets the scan rate.
// Reset clears the control state and sets symbols_in_use to 8; the table is not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
module ambiguity_set_cost_median_top
  import ascm_pkg::*;
#(
  parameter int ALPHABET  = DEF_ALPHABET,
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [SYMS_WIDTH-1:0]     cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation,
  input  logic [MASK_WIDTH-1:0]     left_set,
  input  logic [MASK_WIDTH-1:0]     right_set,
  input  logic [ROW_WIDTH-1:0]      entry_row,
  input  logic [ROW_WIDTH-1:0]      entry_col,
  input  logic [IN_COST_WIDTH-1:0]  entry_cost,
  output logic                      result_valid,
  output logic [OUT_COST_WIDTH-1:0] min_cost,
  output logic [MASK_WIDTH-1:0]     median_set,
  output logic                      no_pair
);

  localparam int NUSE   = (ALPHABET < MASK_WIDTH) ? ALPHABET : MASK_WIDTH;
  localparam int SYM_W  = $clog2(NUSE);
  localparam int DEPTH  = ALPHABET * ALPHABET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = (COST_BITS > OUT_COST_WIDTH) ? COST_BITS : OUT_COST_WIDTH;

  ascm_state_t state, state_next;

  logic [SYMS_WIDTH-1:0] symbols_in_use;
  logic [NUSE-1:0]       keep;
  logic [NUSE-1:0]       lmask_in, rmask_in;
  logic [NUSE-1:0]       lmask, rmask;
  logic [SYM_W-1:0]      scan_i, scan_j;
  logic [SYM_W-1:0]      s_i, s_j;
  logic                  s_valid;
  logic                  accept, wr_en, scan_last;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [COST_BITS-1:0]  cost_mem [DEPTH];
  logic [COST_BITS-1:0]  rd_data;
  logic [MASK_WIDTH-1:0] pair_mask;
  logic [COST_BITS-1:0]  best;
  logic [MASK_WIDTH-1:0] median;
  logic                  any;
  logic [CW-1:0]         best_ext;
  ascm_acc_ctrl_t        acc_ctrl;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    for (int b = 0; b < NUSE; b++) begin
      keep[b] = (SYMS_WIDTH'(b) < symbols_in_use);
    end
  end

  assign lmask_in = left_set[NUSE-1:0] & keep;
  assign rmask_in = right_set[NUSE-1:0] & keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_in_use <= SYMS_RESET;
    end else if (cfg_write) begin
      symbols_in_use <= cfg_data;
    end
  end

  assign wr_en = accept && (operation == OP_WRITE) &&
                 (32'(entry_row) < ALPHABET) && (32'(entry_col) < ALPHABET);
  assign wr_addr = ADDR_W'(32'(entry_row) * ALPHABET + 32'(entry_col));
  assign rd_addr = ADDR_W'(32'(scan_i) * ALPHABET + 32'(scan_j));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cost_mem[wr_addr] <= COST_BITS'(entry_cost);
    end
    rd_data <= cost_mem[rd_addr];
  end

  assign scan_last = (scan_i == SYM_W'(NUSE - 1)) && (scan_j == SYM_W'(NUSE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    acc_ctrl.clear  = 1'b0;
    acc_ctrl.sample = s_valid && lmask[s_i] && rmask[s_j];
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_QUERY) begin
          acc_ctrl.clear = 1'b1;
          if (lmask_in == '0 || rmask_in == '0) begin
            state_next = ST_REPORT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && operation == OP_QUERY) begin
      lmask  <= lmask_in;
      rmask  <= rmask_in;
      scan_i <= '0;
      scan_j <= '0;
    end else if (state == ST_SCAN) begin
      if (scan_j == SYM_W'(NUSE - 1)) begin
        scan_j <= '0;
        scan_i <= scan_i + 1'b1;
      end else begin
        scan_j <= scan_j + 1'b1;
      end
    end
    s_i <= scan_i;
    s_j <= scan_j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= (state == ST_SCAN);
    end
  end

  assign pair_mask = (MASK_WIDTH'(1) << s_i) | (MASK_WIDTH'(1) << s_j);

  ascm_accum #(
    .COST_BITS(COST_BITS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (acc_ctrl),
    .cost     (rd_data),
    .pair_mask(pair_mask),
    .best     (best),
    .median   (median),
    .any      (any)
  );

  assign best_ext = CW'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_REPORT);
    end
    if (state == ST_REPORT) begin
      no_pair    <= !any;
      median_set <= any ? median : '0;
      if (!any || best_ext > CW'(NO_PAIR_COST)) begin
        min_cost <= NO_PAIR_COST;
      end else begin
        min_cost <= best_ext[OUT_COST_WIDTH-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_result_after_report: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_REPORT))
    else $error("result strobe without report state");

  a_no_pair_values: assert property (@(posedge clk) disable iff (rst)
    (result_valid && no_pair) |-> (min_cost == NO_PAIR_COST && median_set == '0))
    else $error("empty-pair result carries data");

  a_pair_has_median: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !no_pair) |-> ($countones(median_set) >= 1))
    else $error("pair found but median empty");

  a_no_sample_when_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_REPORT) |-> !s_valid)
    else $error("scan pipeline active outside scan");

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_last) |=> (state == ST_DRAIN))
    else $error("scan did not drain after last pair");
`endif

endmodule

>>> verif/ambiguity_set_cost_median_top_tb.sv
module ambiguity_set_cost_median_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ascm_pkg::*;

  typedef struct {
    logic                     op;
    logic [MASK_WIDTH-1:0]    left;
    logic [MASK_WIDTH-1:0]    right;
    logic [ROW_WIDTH-1:0]     row;
    logic [ROW_WIDTH-1:0]     col;
    logic [IN_COST_WIDTH-1:0] cost;
  } table_cmd_t;

  typedef struct packed {
    logic [OUT_COST_WIDTH-1:0] cost;
    logic [MASK_WIDTH-1:0]     median;
    logic                      none;
  } cost_median_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [SYMS_WIDTH-1:0]     cfg_data = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      operation = OP_WRITE;
  logic [MASK_WIDTH-1:0]     left_set = '0;
  logic [MASK_WIDTH-1:0]     right_set = '0;
  logic [ROW_WIDTH-1:0]      entry_row = '0;
  logic [ROW_WIDTH-1:0]      entry_col = '0;
  logic [IN_COST_WIDTH-1:0]  entry_cost = '0;
  logic                      result_valid;
  logic [OUT_COST_WIDTH-1:0] min_cost;
  logic [MASK_WIDTH-1:0]     median_set;
  logic                      no_pair;

  table_cmd_t                pending_cmds[$];
  cost_median_t              expected_medians[$];
  logic [IN_COST_WIDTH-1:0]  cost_shadow[DEF_ALPHABET*DEF_ALPHABET];
  logic [SYMS_WIDTH-1:0]     syms_shadow = SYMS_RESET;
  bit                        offer_open = 1'b0;
  int                        cmds_taken = 0;
  int                        fail_count = 0;
  int                        report_count = 0;
  cost_median_t              want;
  cost_median_t              got;

  ambiguity_set_cost_median_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .left_set     (left_set),
    .right_set    (right_set),
    .entry_row    (entry_row),
    .entry_col    (entry_col),
    .entry_cost   (entry_cost),
    .result_valid (result_valid),
    .min_cost     (min_cost),
    .median_set   (median_set),
    .no_pair      (no_pair)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_cost_median(input table_cmd_t cmd);
    int n;
    logic [MASK_WIDTH-1:0] keep;
    logic [MASK_WIDTH-1:0] lm;
    logic [MASK_WIDTH-1:0] rm;
    logic [MASK_WIDTH-1:0] median;
    logic [IN_COST_WIDTH-1:0] best;
    logic [IN_COST_WIDTH-1:0] c;
    bit found;
    cost_median_t res;
    if (cmd.op == OP_WRITE) begin
      cost_shadow[cmd.row * DEF_ALPHABET + cmd.col] = cmd.cost;
      return;
    end
    n = (syms_shadow > MASK_WIDTH) ? MASK_WIDTH : int'(syms_shadow);
    keep = '0;
    for (int k = 0; k < n; k++) keep[k] = 1'b1;
    lm = cmd.left & keep;
    rm = cmd.right & keep;
    if (lm == '0 || rm == '0) begin
      res.cost = NO_PAIR_COST;
      res.median = '0;
      res.none = 1'b1;
    end else begin
      found = 1'b0;
      best = '0;
      median = '0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          if (lm[i] && rm[j]) begin
            c = cost_shadow[i * DEF_ALPHABET + j];
            if (!found || c < best) begin
              found = 1'b1;
              best = c;
              median = '0;
              median[i] = 1'b1;
              median[j] = 1'b1;
            end else if (c == best) begin
              median[i] = 1'b1;
              median[j] = 1'b1;
            end
          end
        end
      end
      res.cost = best;
      res.median = median;
      res.none = 1'b0;
    end
    expected_medians.push_back(res);
  endtask

  // transfer tracking and model update
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) syms_shadow = cfg_data;
      if (offer_open && start && !busy) begin
        predict_cost_median(pending_cmds.pop_front());
        offer_open = 1'b0;
        cmds_taken++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!offer_open) begin
      if (pending_cmds.size() != 0 &&
          !(($urandom_range(99) < 7) && !(cmds_taken >= 200 && cmds_taken < 360))) begin
        operation  <= pending_cmds[0].op;
        left_set   <= pending_cmds[0].left;
        right_set  <= pending_cmds[0].right;
        entry_row  <= pending_cmds[0].row;
        entry_col  <= pending_cmds[0].col;
        entry_cost <= pending_cmds[0].cost;
        start      <= 1'b1;
        offer_open = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      got.cost = min_cost;
      got.median = median_set;
      got.none = no_pair;
      if (expected_medians.size() == 0) begin
        fail_count++;
        if (report_count < 10) begin
          report_count++;
          $display("unexpected result: cost=%h median=%b no_pair=%b",
                   got.cost, got.median, got.none);
        end
      end else begin
        want = expected_medians.pop_front();
        if (got.cost !== want.cost || got.median !== want.median ||
            got.none !== want.none) begin
          fail_count++;
          if (report_count < 10) begin
            report_count++;
            $display("mismatch: expected cost=%h median=%b no_pair=%b, got cost=%h median=%b no_pair=%b",
                     want.cost, want.median, want.none, got.cost, got.median, got.none);
          end
        end
      end
    end
  end

  task automatic push_write(input int r, input int c, input logic [IN_COST_WIDTH-1:0] v);
    table_cmd_t cmd;
    cmd.op = OP_WRITE;
    cmd.left = 8'($urandom);
    cmd.right = 8'($urandom);
    cmd.row = ROW_WIDTH'(r);
    cmd.col = ROW_WIDTH'(c);
    cmd.cost = v;
    pending_cmds.push_back(cmd);
  endtask

  task automatic push_query(input logic [MASK_WIDTH-1:0] l, input logic [MASK_WIDTH-1:0] r);
    table_cmd_t cmd;
    cmd.op = OP_QUERY;
    cmd.left = l;
    cmd.right = r;
    cmd.row = 3'($urandom);
    cmd.col = 3'($urandom);
    cmd.cost = 16'($urandom);
    pending_cmds.push_back(cmd);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || offer_open || expected_medians.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_symbols(input logic [SYMS_WIDTH-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [MASK_WIDTH-1:0] rand_set();
    int mode;
    mode = $urandom_range(99);
    if (mode < 5) return '0;
    if (mode < 10) return '1;
    if (mode < 35) return MASK_WIDTH'(1) << $urandom_range(MASK_WIDTH - 1);
    return MASK_WIDTH'($urandom);
  endfunction

  function automatic logic [IN_COST_WIDTH-1:0] rand_cost();
    int mode;
    mode = $urandom_range(99);
    if (mode < 10) return '0;
    if (mode < 20) return '1;
    if (mode < 60) return IN_COST_WIDTH'($urandom_range(3));
    return IN_COST_WIDTH'($urandom);
  endfunction

  initial begin
    logic [SYMS_WIDTH-1:0] phase_syms[9];
    int guard;
    phase_syms = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd1, 4'd8, 4'd3, 4'd7, 4'd0};
    phase_syms[8] = SYMS_WIDTH'($urandom_range(15));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every table entry before any query can read it
    for (int r = 0; r < DEF_ALPHABET; r++)
      for (int c = 0; c < DEF_ALPHABET; c++)
        push_write(r, c, IN_COST_WIDTH'(17 * ((r > c) ? r - c : c - r)));
    push_write(7, 7, 16'hFFFF);
    push_write(6, 7, 16'hFFFF);

    push_query(8'h00, 8'hFF);
    push_query(8'hFF, 8'h00);
    push_query(8'hFF, 8'hFF);
    push_query(8'h80, 8'h80);
    push_query(8'h80, 8'hC0);
    push_query(8'h01, 8'h80);
    push_query(8'h55, 8'hAA);
    push_query(8'h0F, 8'hF0);
    push_write(2, 5, 16'd0);
    push_write(4, 1, 16'd0);
    push_query(8'h14, 8'h22);
    push_query(8'h3C, 8'h3C);
    push_query(8'hAA, 8'h55);

    foreach (phase_syms[p]) begin
      wait_drained();
      write_symbols(phase_syms[p]);
      push_query(8'hFF, 8'hFF);
      push_query(8'h80, 8'h01);
      for (int k = 0; k < 62; k++) begin
        if ($urandom_range(99) < 25)
          push_write($urandom_range(7), $urandom_range(7), rand_cost());
        else
          push_query(rand_set(), rand_set());
      end
    end

    guard = 0;
    while ((pending_cmds.size() != 0 || offer_open || expected_medians.size() != 0) &&
           guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    fail_count += expected_medians.size();
    if (pending_cmds.size() != 0) fail_count++;

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
